[hdl/sha_pkg.sv]
// Package: SHA-256 constants, round function helpers and shared types.
package sha_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned TOTAL_W = 61;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_EXP_0 = 2'd0;
  localparam logic [1:0] REG_EXP_1 = 2'd1;
  localparam logic [1:0] REG_EXP_2 = 2'd2;
  localparam logic [1:0] REG_EXP_3 = 2'd3;

  typedef logic [31:0] word_t;
  typedef word_t hash_t [8];

  // Start and first-block flag from the sequencer to the compression core
  typedef struct packed {
    logic start;
    logic first;
  } core_ctl_t;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

[hdl/sha_if.sv]
// Interfaces: byte input channel and digest output channel.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part;
  logic [1:0]  part_index;
  logic        match;
  logic        final_part;
  modport source (output valid, digest_part, part_index, match, final_part, input ready);
  modport sink (input valid, digest_part, part_index, match, final_part, output ready);
endinterface

[hdl/sha256_stream_verify.sv]
// Top level: byte stream SHA-256 with padding, digest output and compare.
// Each byte is written into a 64-byte buffer. When a block fills, the
// input is held off through a start state, the round unit (a fetch
// step, 64 rounds with the first 16 schedule words streamed from the
// buffer, a fold step) and the done handshake. On the last byte the block
// is padded one byte per cycle from the marker through byte 63 and then
// compressed; a marker past byte 55 needs a second padded block and
// compression. The four 64-bit digest parts then leave one per accepted
// output word, the fourth carrying the compare result, and the next byte
// is taken from the cycle after the fourth word is accepted.
// Reading a register returns its expected digest part.
module sha256_stream_verify (
  input  logic        clk,
  input  logic        rst,
  sha_in_if.sink      in_ch,
  sha_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import sha_pkg::*;

  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state;
  logic [63:0]        expected [4];
  logic [31:0]        mem [16];
  logic [TOTAL_W-1:0] byte_total;
  logic [5:0]         pos;
  logic               final_blk;
  logic               pad_active;
  logic               mark_done;
  logic               first;
  logic [1:0]         part;
  logic               diff;
  core_ctl_t          ctl;
  logic [3:0]         blk_addr;
  logic [31:0]        blk_word;
  logic               done;
  logic [255:0]       hash;
  logic [63:0]        bits;
  logic [63:0]        cur_part;
  logic [7:0]         wr_byte;
  logic [7:0]         pad_byte;
  logic               wr_en;
  logic [5:0]         wr_pos;
  logic               take;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign prdata  = expected[reg_idx];
  assign bits    = {byte_total, 3'b000};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) expected[i] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_EXP_0: expected[0] <= pwdata;
        REG_EXP_1: expected[1] <= pwdata;
        REG_EXP_2: expected[2] <= pwdata;
        REG_EXP_3: expected[3] <= pwdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state == S_FILL);
  assign take        = in_ch.valid && in_ch.ready;

  // Marker first, then zeros, with the bit length at the end of the last block
  always_comb begin
    pad_byte = 8'h00;
    if (!mark_done) pad_byte = PAD_BYTE;
    else if (final_blk && pos >= 6'd56) pad_byte = bits[63 - 8*(pos - 6'd56) -: 8];
  end

  // Pick the byte written to the block buffer this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = 8'h00;
    wr_pos  = pos;
    if (take) begin
      wr_en   = 1'b1;
      wr_byte = in_ch.data_byte;
    end else if (state == S_PAD) begin
      wr_en   = 1'b1;
      wr_byte = pad_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_pos[5:2]][31 - 8*wr_pos[1:0] -: 8] <= wr_byte;
    blk_word <= mem[blk_addr];
  end

  assign ctl.start = (state == S_RUN);
  assign ctl.first = first;

  sha_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .blk_word (blk_word),
    .blk_addr (blk_addr),
    .done     (done),
    .hash     (hash)
  );

  // Sequencer: fill, pad, compress, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      byte_total <= '0;
      pos        <= '0;
      first      <= 1'b1;
      final_blk  <= 1'b0;
      pad_active <= 1'b0;
      mark_done  <= 1'b0;
      part       <= '0;
      diff       <= 1'b0;
    end else begin
      unique case (state)
        S_FILL: if (take) begin
          byte_total <= byte_total + TOTAL_W'(1);
          pos        <= pos + 6'd1;
          if (in_ch.last_byte) begin
            pad_active <= 1'b1;
            mark_done  <= 1'b0;
            final_blk  <= 1'b0;
          end
          // A full block compresses before any padding
          if (pos == 6'd63) state <= S_RUN;
          else if (in_ch.last_byte) state <= S_PAD;
        end
        S_PAD: begin
          pos <= pos + 6'd1;
          // Length fits in this block when the marker lands before byte 56
          if (!mark_done) begin
            mark_done <= 1'b1;
            final_blk <= (pos <= 6'd55);
          end
          if (pos == 6'd63) state <= S_RUN;
        end
        S_RUN:  state <= S_WAIT;
        S_WAIT: if (done) begin
          first <= 1'b0;
          if (!pad_active) begin
            state <= S_FILL;
          end else if (final_blk) begin
            state <= S_OUT;
            part  <= '0;
            diff  <= 1'b0;
          end else begin
            state     <= S_PAD;
            final_blk <= 1'b1;
          end
        end
        S_OUT: if (out_ch.ready) begin
          part <= part + 2'd1;
          diff <= diff | (cur_part != expected[part]);
          if (part == 2'd3) begin
            state      <= S_FILL;
            first      <= 1'b1;
            byte_total <= '0;
            pos        <= '0;
            pad_active <= 1'b0;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

  assign cur_part           = hash[255 - 64*part -: 64];
  assign out_ch.valid       = (state == S_OUT);
  assign out_ch.digest_part = cur_part;
  assign out_ch.part_index  = part;
  assign out_ch.final_part  = (part == 2'd3);
  assign out_ch.match       = (part == 2'd3) && !diff && (cur_part == expected[3]);

  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> !in_ch.ready)
    else $error("input open while emitting");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_ch.ready && part == 2'd3) |=> state == S_FILL)
    else $error("no restart after digest");
  assert property (@(posedge clk) disable iff (rst) done |-> state == S_WAIT)
    else $error("core done outside wait");
endmodule

[hdl/sha_core.sv]
// Compression core: one SHA-256 round per cycle over a 16-word schedule window.
module sha_core (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::core_ctl_t  ctl,
  input  logic [31:0]         blk_word,
  output logic [3:0]          blk_addr,
  output logic                done,
  output logic [255:0]        hash
);
  import sha_pkg::*;

  logic        busy;
  logic [6:0]  round;
  word_t       h [8];
  word_t       v [8];
  word_t       w [16];
  word_t       wt, t1, t2;

  // Block words are read through a register; round r uses word r-1 for r <= 16
  assign blk_addr = round[3:0];

  always_comb begin
    if (round <= 7'd16) wt = blk_word;
    else wt = sig1(w[14]) + w[9] + sig0(w[1]) + w[0];
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + ROUND_K[6'(round - 7'd1)] + wt;
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Round 0 fetches, rounds 1..64 compress, round 65 folds into hash
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      round <= '0;
      done  <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy  <= 1'b1;
        round <= '0;
        if (ctl.first) begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= INIT_H[i];
            v[i] <= INIT_H[i];
          end
        end else begin
          for (int i = 0; i < 8; i++) v[i] <= h[i];
        end
      end else if (busy) begin
        round <= round + 7'd1;
        if (round >= 7'd1 && round <= 7'd64) begin
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= wt;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        end
        if (round == 7'd65) begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) hash[255 - 32*i -: 32] = h[i];
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy);
  assert property (@(posedge clk) disable iff (rst) (ctl.start && !busy) |=> busy)
    else $error("core did not start");
  assert property (@(posedge clk) disable iff (rst) busy |-> round <= 7'd65)
    else $error("round overrun");
endmodule

[verif/sha_tb_if.sv]
`timescale 1ns / 100ps
// Testbench-side types: the digest word record; channel interfaces come from the RTL.
package sha_tb_pkg;
  typedef struct packed {
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        match;
    logic        final_part;
  } digest_word_t;
endpackage

[verif/sha_digest_checker.sv]
`timescale 1ns / 100ps
// Checker: watches both channels and the register port, predicts SHA-256 digests, compares.
module sha_digest_checker
  import sha_pkg::*;
  import sha_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sha_in_if           in_ch,
  sha_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output int          fail_count,
  output int          pending_words
);

  logic [31:0]  chain [8];
  logic [7:0]   blk_buf [64];
  logic [60:0]  msg_len;
  logic [63:0]  exp_digest [4];
  digest_word_t digest_q [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // run one compression over the buffer into the chaining words
  task automatic fold_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    v = chain;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  // take one byte; on the last one pad, finish and queue four digest words
  task automatic absorb_byte(logic [7:0] b, logic last);
    int pos;
    logic [63:0] bit_len, diff, part;
    digest_word_t dw;
    pos = int'(msg_len[5:0]);
    blk_buf[pos] = b;
    msg_len = msg_len + 61'd1;
    if (pos == 63) fold_block();
    if (last) begin
      bit_len = {msg_len, 3'b000};
      pos = int'(msg_len[5:0]);
      blk_buf[pos] = PAD_BYTE;
      pos++;
      if (pos > 56) begin
        for (int i = pos; i < 64; i++) blk_buf[i] = 8'h00;
        fold_block();
        pos = 0;
      end
      for (int i = pos; i < 56; i++) blk_buf[i] = 8'h00;
      for (int k = 0; k < 8; k++) blk_buf[56+k] = bit_len[63-8*k -: 8];
      fold_block();
      diff = '0;
      for (int k = 0; k < 4; k++) begin
        part = {chain[2*k], chain[2*k+1]};
        diff |= part ^ exp_digest[k];
        dw.digest_part = part;
        dw.part_index = 2'(k);
        dw.match = (k == 3) ? (diff == 0) : 1'b0;
        dw.final_part = (k == 3);
        digest_q.push_back(dw);
      end
      chain = INIT_H;
      msg_len = '0;
    end
  endtask

  // track register writes, input bytes and output words
  always @(posedge clk) begin
    digest_word_t got, want;
    if (rst) begin
      chain = INIT_H;
      msg_len = '0;
      for (int i = 0; i < 4; i++) exp_digest[i] = '0;
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[4:3] <= REG_EXP_3)
        exp_digest[paddr[4:3]] = pwdata;
      if (in_ch.valid && in_ch.ready) absorb_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.digest_part, out_ch.part_index, out_ch.match, out_ch.final_part};
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected digest word %h", got);
        end else begin
          want = digest_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest word mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                       want.digest_part, want.part_index, want.match, want.final_part,
                       got.digest_part, got.part_index, got.match, got.final_part);
          end
        end
      end
    end
    pending_words = digest_q.size();
  end

endmodule

[verif/tb_sha256_stream_verify.sv]
`timescale 1ns / 100ps
// Testbench top: drives bytes, registers and output stalls; reports the verdict.
module tb_sha256_stream_verify;
  import sha_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;
  int          fail_count, pending_words;
  bit          calm_in, calm_out, hold_out;
  int          hold_cycles;
  int          msg_count;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_stream_verify dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sha_digest_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
    .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // stall the digest channel at random, or hold it off while hold_out is set
  initial begin
    out_ch.ready = 1'b0;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_out && hold_cycles < 300) begin
        out_ch.ready <= 1'b0;
        hold_cycles++;
      end else if (calm_out) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(99) >= 14);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // offer one byte and hold it until taken
  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk);
    while (!calm_in && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_message(int len, bit fill_ff);
    for (int i = 0; i < len; i++)
      send_byte(fill_ff ? 8'hff : 8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic drain();
    drop_valid();
    while (pending_words != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int len;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.data_byte = '0; in_ch.last_byte = 1'b0;
    calm_in = 1'b0; calm_out = 1'b0; hold_out = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // one-byte messages at the data extremes and alternating patterns, match against reset zero
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'haa, 1'b1);
    drain();
    // expect the digest of "abc" so the final word flags a match
    reg_write(REG_EXP_0, 64'hba7816bf8f01cfea);
    reg_write(REG_EXP_1, 64'h414140de5dae2223);
    reg_write(REG_EXP_2, 64'hb00361a396177a9c);
    reg_write(REG_EXP_3, 64'hb410ff61f20015ad);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    drain();
    for (int r = 0; r < 4; r++) reg_write(r[1:0], 64'hffffffffffffffff);

    // long hold on the digest side with a second message offered behind it
    hold_out = 1'b1;
    send_message(3, 1'b0);
    send_message(2, 1'b0);
    while (hold_cycles < 300) @(posedge clk);
    hold_out = 1'b0;
    drain();
    for (int r = 0; r < 4; r++) reg_write(r[1:0], {$urandom, $urandom});

    // short random messages around one long calm one: a full block, then a spill
    msg_count = 0;
    while (msg_count < 5) begin
      calm_in = (msg_count == 2);
      calm_out = calm_in;
      len = calm_in ? 120 : $urandom_range(1, 6);
      send_message(len, 1'b0);
      msg_count++;
    end
    calm_in = 1'b0; calm_out = 1'b0;
    drain();

    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
hdl/sha_pkg.sv
hdl/sha_if.sv
hdl/sha_core.sv
hdl/sha256_stream_verify.sv
verif/sha_tb_if.sv
verif/sha_digest_checker.sv
verif/tb_sha256_stream_verify.sv
